// File: rtl/icr_pkg.sv
// Shared types and constants of the index run coalescer.
`timescale 1ns / 1ps

package icr_pkg;

  localparam int unsigned IDX_W           = 32;
  localparam int unsigned LEN_W           = 33;
  localparam int unsigned MAX_INDICES_DEF = 64;
  localparam logic [IDX_W-1:0] GAP_RESET  = IDX_W'(256);

  // Operation applied to every cell of the chain at once.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT
  } cell_op_e;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic             vld;
    logic             gt;
    logic [IDX_W-1:0] val;
  } cell_link_t;

endpackage

// File: rtl/icr_if.sv
// Stream interfaces for the index input and the run output.
`timescale 1ns / 1ps

interface icr_in_if import icr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] element_index;
  logic             final_item;

  modport source (output valid, output element_index, output final_item, input ready);
  modport sink   (input valid, input element_index, input final_item, output ready);
endinterface

interface icr_out_if import icr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] run_start;
  logic [LEN_W-1:0] run_length;
  logic             last_run;
  logic             overflow;

  modport source (output valid, output run_start, output run_length, output last_run,
                  output overflow, input ready);
  modport sink   (input valid, input run_start, input run_length, input last_run,
                  input overflow, output ready);
endinterface

// File: rtl/icr_cell.sv
// One cell of the sorted chain: holds one index and its valid bit.
`timescale 1ns / 1ps

module icr_cell import icr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_op_e         op_i,
  input  logic [IDX_W-1:0] idx_i,
  input  cell_link_t       prev_i,
  input  cell_link_t       next_i,
  output cell_link_t       link_o,
  output logic             eq_o
);

  logic             vld_q;
  logic [IDX_W-1:0] val_q;
  logic             gt;

  // An empty cell counts as larger than any index.
  always_comb begin
    gt     = !vld_q || (val_q > idx_i);
    eq_o   = vld_q && (val_q == idx_i);
    link_o = '{vld: vld_q, gt: gt, val: val_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      unique case (op_i)
        OP_INSERT: if (gt) begin
          vld_q <= prev_i.vld;
        end
        OP_SHIFT:  vld_q <= next_i.vld;
        default:   vld_q <= vld_q;
      endcase
    end
  end

  // Cells above the new index move up by one; the boundary cell takes the index.
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_INSERT: if (gt) begin
        val_q <= prev_i.gt ? prev_i.val : idx_i;
      end
      OP_SHIFT:  val_q <= next_i.val;
      default:   val_q <= val_q;
    endcase
  end

endmodule

// File: rtl/icr_run.sv
// Run builder: merges popped sorted indices into runs and holds the output register.
`timescale 1ns / 1ps

module icr_run import icr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] gap_i,
  input  logic             ovf_i,
  input  logic             pop_i,
  input  logic [IDX_W-1:0] pop_val_i,
  input  logic             pop_last_i,
  output logic             ready_o,
  output logic             done_o,
  icr_out_if.source        out_o
);

  logic             have_q, pend_q, out_vld_q;
  logic [IDX_W-1:0] first_q, last_q;
  logic [IDX_W-1:0] start_q;
  logic [LEN_W-1:0] len_q;
  logic             last_run_q, ovf_q;
  logic             slot_free, brk, emit_final, emit_mid;
  logic [LEN_W-1:0] cur_len;

  assign slot_free  = !out_vld_q || out_o.ready;
  assign ready_o    = slot_free && !pend_q;
  assign brk        = have_q && ((pop_val_i - last_q) > gap_i);
  assign emit_final = slot_free && pend_q;
  assign emit_mid   = ready_o && pop_i && brk;
  assign done_o     = emit_final;
  assign cur_len    = {1'b0, last_q} - {1'b0, first_q} + LEN_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q    <= 1'b0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (emit_final || emit_mid) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (emit_final) begin
        pend_q <= 1'b0;
        have_q <= 1'b0;
      end else if (ready_o && pop_i) begin
        have_q <= 1'b1;
        pend_q <= pop_last_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && pop_i) begin
      last_q <= pop_val_i;
      if (!have_q || brk) begin
        first_q <= pop_val_i;
      end
    end
    if (emit_final || emit_mid) begin
      start_q    <= first_q;
      len_q      <= cur_len;
      last_run_q <= emit_final;
      ovf_q      <= ovf_i;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.run_start  = start_q;
  assign out_o.run_length = len_q;
  assign out_o.last_run   = last_run_q;
  assign out_o.overflow   = ovf_q;

endmodule

// File: rtl/index_run_coalescer.sv
// Top level of the index run coalescer: cell chain, list control and run output.
`timescale 1ns / 1ps

// Indices arrive unsorted, one beat each, and are sorted on entry into a row of
// MAX_INDICES cells; while a list is collected the block takes one index per cycle.
// A repeated index is ignored, and a new index that meets a full row is dropped and
// flags overflow on every run of its list. After the beat with final_item set the
// row shifts out one stored index per cycle into the run builder while the output
// is not held off; no index is taken until the final run of the list has been
// passed to the output register. gap_limit resets to 256 and is to be written
// through cfg_we_i / cfg_wdata_i only while the block is idle; the block itself does not enforce it.

module index_run_coalescer import icr_pkg::*; #(
  parameter int unsigned MAX_INDICES = MAX_INDICES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_wdata_i,
  icr_in_if.sink           in_i,
  icr_out_if.source        out_o
);

  typedef enum logic [1:0] {
    S_COLLECT,
    S_DRAIN,
    S_FINISH
  } state_e;

  localparam cell_link_t HEAD_LINK = '{vld: 1'b1, gt: 1'b0, val: '0};
  localparam cell_link_t TAIL_LINK = '{vld: 1'b0, gt: 1'b1, val: '0};

  state_e                 state_q;
  logic [IDX_W-1:0]       gap_q;
  logic                   dropped_q, ovf_q;
  cell_link_t             link [MAX_INDICES];
  logic [MAX_INDICES-1:0] eq;
  cell_op_e               op;
  logic                   in_acc, dup, full, drop_now;
  logic                   pop, run_rdy, run_done;

  assign in_i.ready = (state_q == S_COLLECT);
  assign in_acc     = in_i.valid && in_i.ready;
  assign dup        = |eq;
  assign full       = link[MAX_INDICES-1].vld;
  assign drop_now   = in_acc && !dup && full;
  assign pop        = (state_q == S_DRAIN) && run_rdy;

  always_comb begin
    op = OP_HOLD;
    if (in_acc && !dup && !full) begin
      op = OP_INSERT;
    end else if (pop) begin
      op = OP_SHIFT;
    end
  end

  for (genvar i = 0; i < MAX_INDICES; i++) begin : g_cell
    cell_link_t prev_l, next_l;
    if (i == 0) begin : g_head
      assign prev_l = HEAD_LINK;
    end else begin : g_mid
      assign prev_l = link[i-1];
    end
    if (i == MAX_INDICES - 1) begin : g_tail
      assign next_l = TAIL_LINK;
    end else begin : g_body
      assign next_l = link[i+1];
    end
    icr_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .op_i   (op),
      .idx_i  (in_i.element_index),
      .prev_i (prev_l),
      .next_i (next_l),
      .link_o (link[i]),
      .eq_o   (eq[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_COLLECT;
      gap_q     <= GAP_RESET;
      dropped_q <= 1'b0;
      ovf_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        gap_q <= cfg_wdata_i;
      end
      unique case (state_q)
        S_COLLECT: if (in_acc) begin
          if (in_i.final_item) begin
            ovf_q     <= dropped_q || drop_now;
            dropped_q <= 1'b0;
            state_q   <= S_DRAIN;
          end else if (drop_now) begin
            dropped_q <= 1'b1;
          end
        end
        S_DRAIN: if (pop && !link[1].vld) begin
          state_q <= S_FINISH;
        end
        S_FINISH: if (run_done) begin
          state_q <= S_COLLECT;
        end
        default: state_q <= S_COLLECT;
      endcase
    end
  end

  icr_run u_run (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .gap_i      (gap_q),
    .ovf_i      (ovf_q),
    .pop_i      (pop),
    .pop_val_i  (link[0].val),
    .pop_last_i (!link[1].vld),
    .ready_o    (run_rdy),
    .done_o     (run_done),
    .out_o      (out_o)
  );

  // Every pop takes a real entry from the head of the row.
  a_pop_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> link[0].vld)
    else $error("pop from an empty cell row");

  // The row is empty while the final run of a list is pending.
  a_empty_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH) |-> !link[0].vld)
    else $error("cells still hold indices after drain");

  // The first two cells stay filled from the head and strictly ascending.
  a_sorted_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    link[1].vld |-> (link[0].vld && (link[0].val < link[1].val)))
    else $error("cell row lost its ascending order");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the index run coalescer: random index lists with a run predictor.
`timescale 1ns / 1ps

module tb_top;
  import icr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = MAX_INDICES_DEF + 8;

  typedef struct packed {
    logic [IDX_W-1:0] first_idx;
    logic [LEN_W-1:0] span;
    logic             last_run;
    logic             overflow;
  } run_t;

  // Keeps a sorted copy of the distinct indices of the open list and
  // queues the runs that the final beat of the list produces.
  class run_scoreboard;
    logic [IDX_W-1:0] sorted_q[$];
    bit               dropped;
    logic [IDX_W-1:0] gap;
    run_t             expected_runs[$];
    int               mismatches;
    int               runs_checked;
    int               lists_closed;
    int               overflow_lists;

    function new();
      dropped = 1'b0;
      gap = GAP_RESET;
      mismatches = 0;
      runs_checked = 0;
      lists_closed = 0;
      overflow_lists = 0;
    endfunction

    function void set_gap(logic [IDX_W-1:0] g);
      gap = g;
    endfunction

    function int pending();
      return expected_runs.size();
    endfunction

    function void push_run(logic [IDX_W-1:0] lo_idx, logic [IDX_W-1:0] hi_idx, logic is_last);
      run_t r;
      r.first_idx = lo_idx;
      r.span      = {1'b0, hi_idx} - {1'b0, lo_idx} + LEN_W'(1);
      r.last_run  = is_last;
      r.overflow  = dropped;
      expected_runs = {expected_runs, r};
    endfunction

    function void note_index(logic [IDX_W-1:0] idx, logic fin);
      int pos;
      logic [IDX_W-1:0] lo_idx;
      logic [IDX_W-1:0] hi_idx;
      pos = 0;
      while (pos < sorted_q.size() && sorted_q[pos] < idx) pos++;
      if (!(pos < sorted_q.size() && sorted_q[pos] == idx)) begin
        if (sorted_q.size() >= MAX_INDICES_DEF) begin
          dropped = 1'b1;
        end else begin
          sorted_q.insert(pos, idx);
        end
      end
      if (!fin) return;
      lo_idx = sorted_q[0];
      hi_idx = lo_idx;
      for (int i = 1; i < sorted_q.size(); i++) begin
        if (sorted_q[i] - hi_idx > gap) begin
          push_run(lo_idx, hi_idx, 1'b0);
          lo_idx = sorted_q[i];
        end
        hi_idx = sorted_q[i];
      end
      push_run(lo_idx, hi_idx, 1'b1);
      lists_closed++;
      if (dropped) overflow_lists++;
      sorted_q.delete();
      dropped = 1'b0;
    endfunction

    function void check_run(run_t got);
      run_t want;
      runs_checked++;
      if (expected_runs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected run: start=%h len=%h last=%b ovf=%b", $realtime,
                   got.first_idx, got.span, got.last_run, got.overflow);
        return;
      end
      want = expected_runs.pop_front();
      if (got.first_idx !== want.first_idx || got.span !== want.span ||
          got.last_run !== want.last_run || got.overflow !== want.overflow) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"[%0t] run mismatch: expected start=%h len=%h last=%b ovf=%b,",
                    " got start=%h len=%h last=%b ovf=%b"},
                   $realtime, want.first_idx, want.span, want.last_run, want.overflow,
                   got.first_idx, got.span, got.last_run, got.overflow);
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_wdata;

  icr_in_if  in_if ();
  icr_out_if out_if ();

  index_run_coalescer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  run_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int          items_sent = 0;
  int          gap_writes = 0;
  int          hold_request = 0;
  bit          steady = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d runs still expected", cycle_count, sb.pending());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Mostly no pause, sometimes a short one, rarely a long one.
  function automatic int rand_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Output side: checks every accepted beat and throttles ready.
  initial begin : run_sink
    int   stall_left;
    run_t got;
    stall_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got.first_idx = out_if.run_start;
        got.span      = out_if.run_length;
        got.last_run  = out_if.last_run;
        got.overflow  = out_if.overflow;
        sb.check_run(got);
      end
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        stall_left = rand_pause();
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Offers one index beat and returns at the edge where it is taken. With no
  // pause, valid stays high so the next call can follow in the same step.
  task automatic send_item(input logic [IDX_W-1:0] idx, input logic fin);
    int pause;
    in_if.valid         <= 1'b1;
    in_if.element_index <= idx;
    in_if.final_item    <= fin;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_index(idx, fin);
    items_sent++;
    pause = steady ? 0 : rand_pause();
    if (pause > 0) begin
      in_if.valid <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
  endtask

  // Waits until every expected run has arrived and the drain has settled.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_gap(input logic [IDX_W-1:0] g);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.set_gap(g);
    gap_writes++;
  endtask

  // One list of n beats: clustered around a base so gaps matter, near either
  // end of the index range, or spread over the full range; some repeats.
  task automatic send_random_list(input int n);
    logic [IDX_W-1:0] base;
    logic [IDX_W-1:0] spread;
    logic [IDX_W-1:0] v;
    logic [IDX_W-1:0] sent[$];
    int               mode;
    mode   = $urandom_range(0, 3);
    spread = (sb.gap < 32'h0FFF_FFFF) ? sb.gap * 3 + 3 : 32'hFFFF_FFFF;
    case (mode)
      0: base = $urandom();
      1: base = '0;
      2: base = 32'hFFFF_FFFF - $urandom_range(0, 40);
      default: base = $urandom();
    endcase
    for (int i = 0; i < n; i++) begin
      if (sent.size() > 0 && $urandom_range(0, 4) == 0) begin
        v = sent[$urandom_range(0, sent.size() - 1)];
      end else if (mode == 3) begin
        v = $urandom();
      end else begin
        v = base + $urandom_range(0, spread);
      end
      sent = {sent, v};
      send_item(v, i == n - 1);
    end
  endtask

  initial begin : stimulus
    int r;
    int n;
    int phase_end;
    logic [IDX_W-1:0] g;

    rst_ni              <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    in_if.valid         <= 1'b0;
    in_if.element_index <= '0;
    in_if.final_item    <= 1'b0;
    out_if.ready        <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lists under the reset gap: single values at both ends,
    // repeats, a difference of exactly the gap and one just above it.
    send_item(32'h0000_0000, 1'b1);
    send_item(32'hFFFF_FFFF, 1'b1);
    send_item(32'd7, 1'b0);
    send_item(32'd7, 1'b0);
    send_item(32'd7, 1'b1);
    send_item(32'd614, 1'b0);
    send_item(32'd100, 1'b0);
    send_item(32'd356, 1'b0);
    send_item(32'd357, 1'b1);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b1);
    wait_idle();

    // Zero gap splits even adjacent indices.
    write_gap(32'h0000_0000);
    send_item(32'd10, 1'b0);
    send_item(32'd11, 1'b0);
    send_item(32'd12, 1'b0);
    send_item(32'd12, 1'b1);
    wait_idle();

    // Widest gap bridges the whole index range into one run of 2^32.
    write_gap(32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'h5555_AAAA, 1'b1);
    wait_idle();

    write_gap(32'd1);
    send_item(32'd20, 1'b0);
    send_item(32'd21, 1'b0);
    send_item(32'd23, 1'b1);
    wait_idle();

    // More distinct indices than the store holds, with repeats mixed in.
    write_gap($urandom_range(0, 300));
    for (int i = 0; i < 75; i++) begin
      send_item((i % 9 == 8) ? 32'd5 : $urandom(), i == 74);
    end
    wait_idle();

    // The sink holds off while two lists follow back to back, so the drain
    // stalls and the input side is held off behind it.
    hold_request = 300;
    send_random_list(20);
    send_random_list(12);
    wait_idle();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: g = GAP_RESET;
        1: g = 32'h0000_0000;
        2: g = 32'd1;
        3: g = 32'hFFFF_FFFF;
        4: g = $urandom_range(2, 64);
        5: g = $urandom();
        6: g = $urandom_range(100, 5000);
        default: g = 32'h0000_0000;
      endcase
      write_gap(g);
      steady = (phase == 2 || phase == 5);
      phase_end = items_sent + 25;
      while (items_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 85) n = $urandom_range(1, 12);
        else if (r < 95) n = $urandom_range(13, 40);
        else n = $urandom_range(60, 75);
        send_random_list(n);
      end
      wait_idle();
      steady = 1'b0;
    end

    $display("sent %0d index beats in %0d lists (%0d of them overflowed), checked %0d runs",
             items_sent, sb.lists_closed, sb.overflow_lists, sb.runs_checked);
    $display("gap register written %0d times, including zero and the full 32-bit value",
             gap_writes);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d runs never arrived", sb.mismatches, sb.pending());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/icr_pkg.sv
rtl/icr_if.sv
rtl/icr_cell.sv
rtl/icr_run.sv
rtl/index_run_coalescer.sv
tb/tb_top.sv
